FILE: hw/rtl/ffca_pkg.sv
package ffca_pkg;

	localparam int ADDR_BITS = 16;
	localparam int SIZE_BITS = 17;
	localparam int SLOT_BITS = 14;
	localparam int SEG_BITS = 14;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 17;
	localparam logic [SLOT_BITS:0] WALK_LIMIT = (SLOT_BITS + 1)'(1 << SLOT_BITS);

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_HEAP_BASE   = 2'd0,
		REG_HEAP_BYTES  = 2'd1,
		REG_ALIGN_SHIFT = 2'd2,
		REG_HEADER      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [15:0]           request_bytes;
		logic [ADDR_BITS-1:0]  block_address;
	} item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [ADDR_BITS-1:0]  granted_address;
		logic [SIZE_BITS-1:0]  free_bytes;
	} result_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0]  next;
		logic [SIZE_BITS-1:0]  size;
		logic                  used;
	} hdr_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT1,
		S_INIT2,
		S_INIT3,
		S_AL_HEAD,
		S_AL_BLK,
		S_AL_WAIT,
		S_AL_CHECK,
		S_AL_PREV,
		S_FR_HDR,
		S_FR_WAIT,
		S_FR_CHECK,
		S_INS_RD,
		S_INS_WAIT,
		S_INS_NXT,
		S_INS_NWAIT,
		S_INS_WR1,
		S_INS_WR2,
		S_AL_MARK,
		S_DONE
	} state_t;

	function automatic logic [SLOT_BITS-1:0] slot_of(input logic [ADDR_BITS-1:0] a);
		return a[SLOT_BITS+1:2];
	endfunction

endpackage

FILE: hw/rtl/first_fit_coalescing_allocator_core.sv
// channel | direction | handshake       | payload
// command | in        | start & !busy   | cmd (opcode, request_bytes, block_address)
// result  | out       | done strobe     | result (status, granted_address, free_bytes)
// config  | in        | cfg_valid/ready | cfg_index, cfg_data
//
// allocate and free walk the header memory through its single port: read data
// comes back registered (address, then registered data), so each list link
// visited costs a read and its wait, and the writes follow at the end; a good
// init writes its three headers (INIT1, INIT2, INIT3), a rejected one goes on
// to DONE. reset clears the state, config and main control registers, not the memory.
// the result is shown for one cycle on done and cannot be stalled.
module first_fit_coalescing_allocator_core
	import ffca_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  item_t                     cmd,
	output logic                      done,
	output result_t                   result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam logic [ADDR_BITS:0] ASPACE = {1'b1, {ADDR_BITS{1'b0}}};

	// header memory
	hdr_t mem [2**SLOT_BITS];
	hdr_t rd_data;
	logic                  mem_we;
	logic [SLOT_BITS-1:0]  mem_addr;
	hdr_t                  mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rd_data <= mem[mem_addr];
	end

	// config
	logic [ADDR_BITS-1:0]  base_q;
	logic [SIZE_BITS-1:0]  hbytes_q;
	logic [1:0]            ash_q;
	logic [4:0]            hdr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			hbytes_q <= SIZE_BITS'(65536);
			ash_q    <= 2'd2;
			hdr_q    <= 5'd4;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_HEAP_BASE:   base_q   <= cfg_data[ADDR_BITS-1:0];
				REG_HEAP_BYTES:  hbytes_q <= cfg_data;
				REG_ALIGN_SHIFT: ash_q    <= cfg_data[1:0];
				REG_HEADER:      hdr_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// control state
	state_t state_q, state_d;
	logic                  ready_q;
	logic [ADDR_BITS-1:0]  head_q, endm_q;
	logic [SIZE_BITS-1:0]  rem_q;
	logic [SEG_BITS-1:0]   seg_q;
	logic [1:0]            status_q;
	logic [ADDR_BITS-1:0]  grant_q;
	logic                  is_alloc_q;
	logic [SLOT_BITS:0]    steps_q;
	logic [ADDR_BITS-1:0]  prev_q, blk_q, it_q, ins_addr_q, first_q;
	hdr_t                  prev_h_q, blk_h_q, it_h_q;
	logic [SIZE_BITS-1:0]  wanted_q, ins_size_q;
	logic [ADDR_BITS-1:0]  pv_q;
	logic [15:0]           req_q;

	// init arithmetic on the captured registers
	logic [ADDR_BITS:0]    am_w, space_w, avail_w, limit_w, first_w, end_w;
	logic                  init_ok;

	always_comb begin
		am_w    = (ADDR_BITS+1)'((1 << ash_q) - 1);
		space_w = ASPACE - {1'b0, base_q};
		avail_w = (hbytes_q < space_w) ? hbytes_q : space_w;
		limit_w = {1'b0, base_q} + avail_w;
		first_w = ({1'b0, base_q} + (ADDR_BITS+1)'(hdr_q) + am_w) & ~am_w;
		end_w   = (limit_w - (ADDR_BITS+1)'(hdr_q)) & ~am_w;
		init_ok = !(limit_w < first_w + (ADDR_BITS+1)'(hdr_q)) && !(end_w <= first_w)
			&& !end_w[ADDR_BITS];
	end

	// helper arithmetic
	logic [SIZE_BITS:0]    wanted_w;
	logic [ADDR_BITS-1:0]  hdr_addr_w;
	logic [ADDR_BITS+1:0]  free_end_w;
	logic [SIZE_BITS:0]    rem_sum_w;
	logic [SIZE_BITS-1:0]  left_w;
	logic                  it_merge, nx_merge;
	logic [ADDR_BITS-1:0]  blk_addr_w;
	logic [SIZE_BITS-1:0]  bsize_a_w;

	always_comb begin
		wanted_w   = ({2'b0, req_q} + (SIZE_BITS+1)'(hdr_q) + (SIZE_BITS+1)'(am_w))
			& ~(SIZE_BITS+1)'(am_w);
		hdr_addr_w = pv_q - ADDR_BITS'(hdr_q);
		free_end_w = {2'b0, pv_q - ADDR_BITS'(hdr_q)} + (ADDR_BITS+2)'(rd_data.size);
		rem_sum_w  = {1'b0, rem_q} + {1'b0, rd_data.size};
		left_w     = blk_h_q.size - wanted_q;
		it_merge   = (it_q + ADDR_BITS'(it_h_q.size)) == ins_addr_q;
		blk_addr_w = it_merge ? it_q : ins_addr_q;
		bsize_a_w  = it_merge ? it_h_q.size + ins_size_q : ins_size_q;
		nx_merge   = (blk_addr_w + ADDR_BITS'(bsize_a_w)) == it_h_q.next;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (start) begin
					case (opcode_t'(cmd.opcode))
						OP_INIT:  state_d = S_INIT1;
						OP_ALLOC: state_d = S_AL_HEAD;
						OP_FREE:  state_d = S_FR_HDR;
						default:  state_d = S_DONE;
					endcase
				end
			S_INIT1:    state_d = init_ok ? S_INIT2 : S_DONE;
			S_INIT2:    state_d = S_INIT3;
			S_INIT3:    state_d = S_DONE;
			S_AL_HEAD:
				if (req_q == '0 || !ready_q || wanted_w > {1'b0, rem_q})
					state_d = S_DONE;
				else
					state_d = S_AL_BLK;
			S_AL_BLK:   state_d = S_AL_WAIT;
			S_AL_WAIT:  state_d = S_AL_CHECK;
			S_AL_CHECK:
				if (rd_data.size < wanted_q && rd_data.next != '0) begin
					state_d = (steps_q == WALK_LIMIT) ? S_DONE : S_AL_WAIT;
				end else if (blk_q == endm_q || rd_data.size < wanted_q)
					state_d = S_DONE;
				else
					state_d = S_AL_PREV;
			S_AL_PREV:
				state_d = (left_w > SIZE_BITS'({hdr_q, 1'b0})) ? S_INS_RD : S_AL_MARK;
			S_FR_HDR:
				if (pv_q == '0 || !ready_q || hdr_addr_w < first_q || hdr_addr_w >= endm_q)
					state_d = S_DONE;
				else
					state_d = S_FR_WAIT;
			S_FR_WAIT:  state_d = S_FR_CHECK;
			S_FR_CHECK:
				if (!rd_data.used || rd_data.next != '0 || rd_data.size == '0
					|| free_end_w > {2'b0, endm_q})
					state_d = S_DONE;
				else
					state_d = S_INS_RD;
			S_INS_RD:   state_d = S_INS_WAIT;
			S_INS_WAIT:
				if (rd_data.next < ins_addr_q) begin
					// a dropped insert still lets the allocate mark its block
					if (steps_q == WALK_LIMIT)
						state_d = is_alloc_q ? S_AL_MARK : S_DONE;
					else
						state_d = S_INS_RD;
				end else
					state_d = S_INS_NXT;
			S_INS_NXT:  state_d = S_INS_NWAIT;
			S_INS_NWAIT: state_d = S_INS_WR1;
			S_INS_WR1:  state_d = S_INS_WR2;
			S_INS_WR2:  state_d = is_alloc_q ? S_AL_MARK : S_DONE;
			S_AL_MARK:  state_d = S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		case (state_q)
			S_INIT1: begin
				mem_we    = init_ok;
				mem_addr  = slot_of(first_w[ADDR_BITS-1:0] - ADDR_BITS'(hdr_q));
				mem_wdata = '{next: first_w[ADDR_BITS-1:0], size: '0, used: 1'b0};
			end
			S_INIT2: begin
				mem_we    = 1'b1;
				mem_addr  = slot_of(endm_q);
				mem_wdata = '{next: '0, size: '0, used: 1'b0};
			end
			S_INIT3: begin
				mem_we    = 1'b1;
				mem_addr  = slot_of(first_q);
				mem_wdata = '{next: endm_q, size: SIZE_BITS'(endm_q - first_q), used: 1'b0};
			end
			S_AL_HEAD:   mem_addr = slot_of(head_q);
			S_AL_BLK:    mem_addr = slot_of(rd_data.next);
			S_AL_WAIT:   mem_addr = slot_of(blk_q);
			S_AL_CHECK:  mem_addr = slot_of(rd_data.next);
			S_AL_PREV: begin
				mem_we    = 1'b1;
				mem_addr  = slot_of(prev_q);
				mem_wdata = '{next: blk_h_q.next, size: prev_h_q.size, used: prev_h_q.used};
			end
			S_FR_HDR:    mem_addr = slot_of(hdr_addr_w);
			S_FR_WAIT:   mem_addr = slot_of(hdr_addr_w);
			S_INS_RD:    mem_addr = slot_of(it_q);
			S_INS_NXT:   mem_addr = slot_of(it_h_q.next);
			S_INS_WR1: begin
				mem_we    = !it_merge;
				mem_addr  = slot_of(it_q);
				mem_wdata = '{next: blk_addr_w, size: it_h_q.size, used: it_h_q.used};
			end
			S_INS_WR2: begin
				mem_we    = 1'b1;
				mem_addr  = slot_of(blk_addr_w);
				mem_wdata.used = 1'b0;
				if (nx_merge && it_h_q.next != endm_q) begin
					mem_wdata.size = bsize_a_w + blk_h_q.size;
					mem_wdata.next = blk_h_q.next;
				end else begin
					mem_wdata.size = bsize_a_w;
					mem_wdata.next = it_h_q.next;
				end
			end
			S_AL_MARK: begin
				mem_we    = 1'b1;
				mem_addr  = slot_of(grant_q - ADDR_BITS'(hdr_q));
				mem_wdata = '{next: '0, size: wanted_q, used: 1'b1};
			end
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = (state_q == S_DONE);
		result = '{status: status_q, granted_address: grant_q, free_bytes: rem_q};
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ready_q  <= 1'b0;
			head_q   <= '0;
			endm_q   <= '0;
			first_q  <= '0;
			rem_q    <= '0;
			seg_q    <= '0;
			status_q <= ST_OK;
			grant_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE:
					if (start) begin
						status_q   <= ST_OK;
						grant_q    <= '0;
						req_q      <= cmd.request_bytes;
						pv_q       <= cmd.block_address;
						is_alloc_q <= 1'b0;
						steps_q    <= '0;
					end
				S_INIT1: begin
					ready_q <= init_ok;
					seg_q   <= init_ok ? SEG_BITS'(3) : '0;
					if (init_ok) begin
						head_q  <= first_w[ADDR_BITS-1:0] - ADDR_BITS'(hdr_q);
						first_q <= first_w[ADDR_BITS-1:0];
						endm_q  <= end_w[ADDR_BITS-1:0];
						rem_q   <= SIZE_BITS'(end_w - first_w);
					end else begin
						head_q   <= '0;
						first_q  <= ADDR_BITS'(hdr_q);
						endm_q   <= '0;
						rem_q    <= '0;
						status_q <= ST_NOSPACE;
					end
				end
				S_AL_HEAD: begin
					prev_q   <= head_q;
					wanted_q <= wanted_w[SIZE_BITS-1:0];
					if (req_q == '0)
						status_q <= ST_ZERO;
					else if (!ready_q || wanted_w > {1'b0, rem_q})
						status_q <= ST_NOSPACE;
				end
				S_AL_BLK: begin
					prev_h_q <= rd_data;
					blk_q    <= rd_data.next;
				end
				S_AL_CHECK: begin
					blk_h_q <= rd_data;
					if (rd_data.size < wanted_q && rd_data.next != '0) begin
						steps_q  <= steps_q + 1'b1;
						prev_q   <= blk_q;
						prev_h_q <= rd_data;
						blk_q    <= rd_data.next;
						if (steps_q == WALK_LIMIT)
							status_q <= ST_NOSPACE;
					end else if (blk_q == endm_q || rd_data.size < wanted_q)
						status_q <= ST_NOSPACE;
					else
						grant_q <= blk_q + ADDR_BITS'(hdr_q);
				end
				S_AL_PREV: begin
					steps_q <= '0;
					it_q    <= head_q;
					if (left_w > SIZE_BITS'({hdr_q, 1'b0})) begin
						is_alloc_q <= 1'b1;
						ins_addr_q <= blk_q + ADDR_BITS'(wanted_q);
						ins_size_q <= left_w;
						seg_q      <= seg_q + 1'b1;
						rem_q      <= (rem_q >= wanted_q) ? rem_q - wanted_q : '0;
					end else begin
						wanted_q <= blk_h_q.size;
						rem_q    <= (rem_q >= blk_h_q.size) ? rem_q - blk_h_q.size : '0;
					end
				end
				S_FR_CHECK: begin
					it_q       <= head_q;
					ins_addr_q <= hdr_addr_w;
					ins_size_q <= rd_data.size;
					if (!(!rd_data.used || rd_data.next != '0 || rd_data.size == '0
						|| free_end_w > {2'b0, endm_q}))
						rem_q <= rem_sum_w[SIZE_BITS] ? '1 : rem_sum_w[SIZE_BITS-1:0];
				end
				S_INS_WAIT: begin
					it_h_q <= rd_data;
					if (rd_data.next < ins_addr_q) begin
						steps_q <= steps_q + 1'b1;
						it_q    <= rd_data.next;
					end
				end
				S_INS_NWAIT: blk_h_q <= rd_data;
				S_INS_WR2:
					seg_q <= seg_q - SEG_BITS'(it_merge)
						- SEG_BITS'(nx_merge && it_h_q.next != endm_q);
				default: ;
			endcase
		end
	end

endmodule

FILE: test/ffca_checker.sv
module ffca_checker
	import ffca_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  item_t                     cmd,
	input  logic                      done,
	input  result_t                   result,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        errors
);

	localparam int unsigned SLOTS = 1 << SLOT_BITS;
	localparam int unsigned AMASK = (1 << ADDR_BITS) - 1;
	localparam int unsigned SMASK = (1 << SIZE_BITS) - 1;

	// header store, one entry per 4-byte word
	bit [ADDR_BITS-1:0] hdr_next [SLOTS];
	bit [SIZE_BITS-1:0] hdr_size [SLOTS];
	bit                 hdr_used [SLOTS];

	int unsigned head_addr, marker_addr, free_left;
	bit          heap_up;
	int unsigned base_reg, bytes_reg, shift_reg, hsize_reg;

	result_t outcome_q [$];

	function automatic int unsigned slot(int unsigned a);
		return (a >> 2) % SLOTS;
	endfunction

	function automatic void hdr_put(int unsigned a, int unsigned nxt, int unsigned sz,
			int unsigned used);
		hdr_next[slot(a)] = ADDR_BITS'(nxt & AMASK);
		hdr_size[slot(a)] = SIZE_BITS'(sz & SMASK);
		hdr_used[slot(a)] = used[0];
	endfunction

	// address-ordered insert with merging on both sides
	function automatic void link_free(int unsigned addr, int unsigned size);
		int unsigned it, steps, itn, blk, bsz, bnx;
		it = head_addr;
		steps = 0;
		while (hdr_next[slot(it)] < addr) begin
			steps++;
			if (steps > SLOTS)
				return;
			it = hdr_next[slot(it)];
		end
		itn = hdr_next[slot(it)];
		blk = addr;
		bsz = size & SMASK;
		if (((it + hdr_size[slot(it)]) & AMASK) == addr) begin
			bsz = (hdr_size[slot(it)] + bsz) & SMASK;
			blk = it;
		end
		if (((blk + bsz) & AMASK) == itn) begin
			if (itn != marker_addr) begin
				bsz = (bsz + hdr_size[slot(itn)]) & SMASK;
				bnx = hdr_next[slot(itn)];
			end else begin
				bnx = marker_addr;
			end
		end else begin
			bnx = itn;
		end
		if (it != blk)
			hdr_put(it, blk, hdr_size[slot(it)], hdr_used[slot(it)]);
		hdr_put(blk, bnx, bsz, 0);
	endfunction

	function automatic status_t heap_init();
		longint unsigned am, b, room, avail, lim, first, e;
		am = (64'd1 << shift_reg) - 1;
		b = base_reg;
		room = 65536 - b;
		avail = (bytes_reg < room) ? bytes_reg : room;
		lim = b + avail;
		first = (b + hsize_reg + am) & ~am;
		heap_up = 0;
		free_left = 0;
		head_addr = 0;
		marker_addr = 0;
		if (lim < first + hsize_reg)
			return ST_NOSPACE;
		e = (lim - hsize_reg) & ~am;
		if (e <= first || e > AMASK)
			return ST_NOSPACE;
		head_addr = 32'((first - hsize_reg) & AMASK);
		marker_addr = 32'(e);
		hdr_put(head_addr, 32'(first), 0, 0);
		hdr_put(marker_addr, 0, 0, 0);
		hdr_put(32'(first), marker_addr, 32'(e - first), 0);
		free_left = 32'((e - first) & SMASK);
		heap_up = 1;
		return ST_OK;
	endfunction

	function automatic status_t heap_alloc(int unsigned req, output int unsigned granted);
		int unsigned am, wanted, prev, blk, bsz, bnx, steps;
		granted = 0;
		am = (1 << shift_reg) - 1;
		steps = 0;
		if (req == 0)
			return ST_ZERO;
		if (!heap_up)
			return ST_NOSPACE;
		wanted = (req + hsize_reg + am) & ~am;
		if (wanted > free_left)
			return ST_NOSPACE;
		prev = head_addr;
		blk = hdr_next[slot(prev)];
		while (hdr_size[slot(blk)] < wanted && hdr_next[slot(blk)] != 0) begin
			steps++;
			if (steps > SLOTS)
				return ST_NOSPACE;
			prev = blk;
			blk = hdr_next[slot(blk)];
		end
		if (blk == marker_addr || hdr_size[slot(blk)] < wanted)
			return ST_NOSPACE;
		granted = (blk + hsize_reg) & AMASK;
		bsz = hdr_size[slot(blk)];
		bnx = hdr_next[slot(blk)];
		hdr_put(prev, bnx, hdr_size[slot(prev)], hdr_used[slot(prev)]);
		if (bsz - wanted > 2 * hsize_reg) begin
			link_free((blk + wanted) & AMASK, bsz - wanted);
			bsz = wanted;
		end
		free_left = (free_left >= bsz) ? free_left - bsz : 0;
		hdr_put(blk, 0, bsz, 1);
		return ST_OK;
	endfunction

	function automatic void heap_release(int unsigned pv);
		int unsigned hdr, first, size;
		longint unsigned sum;
		if (pv == 0 || !heap_up)
			return;
		hdr = (pv - hsize_reg) & AMASK;
		first = (head_addr + hsize_reg) & AMASK;
		if (hdr < first || hdr >= marker_addr)
			return;
		if (!hdr_used[slot(hdr)] || hdr_next[slot(hdr)] != 0)
			return;
		size = hdr_size[slot(hdr)];
		if (size == 0 || longint'(hdr) + size > marker_addr)
			return;
		sum = longint'(free_left) + size;
		free_left = (sum > SMASK) ? SMASK : 32'(sum);
		link_free(hdr, size);
	endfunction

	initial begin
		head_addr = 0;
		marker_addr = 0;
		free_left = 0;
		heap_up = 0;
		base_reg = 0;
		bytes_reg = 65536;
		shift_reg = 2;
		hsize_reg = 4;
		errors = 0;
	end

	always @(posedge clk) begin
		result_t want;
		int unsigned g;
		if (arst_n) begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: status %0d addr %h free %0d",
							result.status, result.granted_address, result.free_bytes);
				end else begin
					want = outcome_q.pop_front();
					if (result.status !== want.status
							|| result.granted_address !== want.granted_address
							|| result.free_bytes !== want.free_bytes) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp status %0d addr %h free %0d, got %0d %h %0d",
								want.status, want.granted_address, want.free_bytes,
								result.status, result.granted_address, result.free_bytes);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_HEAP_BASE:   base_reg = cfg_data[15:0];
					REG_HEAP_BYTES:  bytes_reg = cfg_data[16:0];
					REG_ALIGN_SHIFT: shift_reg = cfg_data[1:0];
					REG_HEADER:      hsize_reg = cfg_data[4:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				g = 0;
				want.status = ST_OK;
				case (opcode_t'(cmd.opcode))
					OP_INIT:  want.status = heap_init();
					OP_ALLOC: want.status = heap_alloc(cmd.request_bytes, g);
					OP_FREE:  heap_release(cmd.block_address);
					default: ;
				endcase
				want.granted_address = g[ADDR_BITS-1:0];
				want.free_bytes = free_left[SIZE_BITS-1:0];
				outcome_q.push_back(want);
			end
		end
	end

endmodule

FILE: test/tb_top.sv
module tb_top;
	import ffca_pkg::*;

	localparam int LIMIT = 20000000;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	item_t                     cmd;
	logic                      done;
	result_t                   result;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        errors;

	opcode_t     sent_ops [$];
	int unsigned live_blocks [$];
	int unsigned cur_base, cur_hsize;
	int          sent, cycles;

	first_fit_coalescing_allocator_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ffca_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[first_fit_coalescing_allocator_core] ERROR");
			$finish;
		end
	end

	// granted blocks become candidates for release
	always @(posedge clk) begin
		opcode_t op;
		if (arst_n && done && sent_ops.size() != 0) begin
			op = sent_ops.pop_front();
			if (op == OP_ALLOC && result.status == ST_OK)
				live_blocks.push_back(result.granted_address);
		end
	end

	task automatic send(opcode_t op, int unsigned req, int unsigned pv);
		int pct;
		pct = (sent < 450) ? 26 : (sent < 900) ? 45 : 0;
		while ($urandom_range(99) < pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		cmd <= '{opcode: op, request_bytes: req[15:0], block_address: pv[15:0]};
		do @(posedge clk); while (busy);
		sent_ops.push_back(op);
		sent++;
	endtask

	task automatic drain();
		start <= 0;
		while (sent_ops.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic cfg_put(reg_idx_t idx, int unsigned d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d[CFG_DATA_BITS-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic reconfigure(int unsigned b, int unsigned n, int unsigned s, int unsigned h);
		drain();
		cfg_put(REG_HEAP_BASE, b);
		cfg_put(REG_HEAP_BYTES, n);
		cfg_put(REG_ALIGN_SHIFT, s);
		cfg_put(REG_HEADER, h);
		cfg_valid <= 0;
		cur_base = b;
		cur_hsize = h;
		live_blocks.delete();
		send(OP_INIT, $urandom, $urandom);
	endtask

	// address that the block must drop without touching an unwritten header
	function automatic int unsigned stray_addr();
		int unsigned top;
		top = cur_base + 2 * cur_hsize - 1;
		return $urandom_range(0, (top > 65535) ? 65535 : top);
	endfunction

	task automatic random_items(int n);
		int unsigned r, req, pv, k;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 2) begin
				drain();
				live_blocks.delete();
				send(OP_INIT, $urandom, $urandom);
			end else if (r < 50) begin
				k = $urandom_range(99);
				if (k < 3)
					req = 0;
				else if (k < 10)
					req = $urandom_range(0, 65535);
				else if (k < 25)
					req = $urandom_range(49, 600);
				else
					req = $urandom_range(1, 48);
				send(OP_ALLOC, req, $urandom);
			end else if (r < 95) begin
				if (live_blocks.size() != 0 && $urandom_range(99) < 88) begin
					k = $urandom_range(0, live_blocks.size() - 1);
					pv = live_blocks[k];
					live_blocks.delete(k);
				end else begin
					pv = stray_addr();
				end
				send(OP_FREE, $urandom, pv);
			end else begin
				send(OP_NOP, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		int unsigned a1, a2;
		arst_n = 0;
		start = 0;
		cmd = '0;
		cfg_valid = 0;
		cfg_index = REG_HEAP_BASE;
		cfg_data = '0;
		sent = 0;
		cycles = 0;
		cur_base = 0;
		cur_hsize = 4;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// use before init, then the basic operations on the reset settings
		send(OP_NOP, 16'hFFFF, 16'hFFFF);
		send(OP_ALLOC, 100, 0);
		send(OP_FREE, 0, 16'h0040);
		send(OP_INIT, 0, 0);
		send(OP_ALLOC, 0, 0);
		send(OP_ALLOC, 1, 0);
		send(OP_ALLOC, 16'hFFFF, 0);
		send(OP_ALLOC, 300, 0);
		drain();
		a2 = live_blocks.pop_back();
		a1 = live_blocks.pop_back();
		send(OP_FREE, 0, a1);
		send(OP_FREE, 16'hFFFF, a1);
		send(OP_FREE, 0, 0);
		send(OP_FREE, 0, 2);
		send(OP_FREE, 0, a2);
		send(OP_ALLOC, 40, 0);
		send(OP_ALLOC, 8, 0);
		send(OP_NOP, 0, 0);
		send(OP_INIT, 0, 0);
		random_items(330);

		reconfigure(16'h1234, 4000, 3, 8);
		random_items(250);
		// region clipped at the top of the address space
		reconfigure(16'hFF00, 65536, 0, 4);
		random_items(120);
		reconfigure(0, 65536, 1, 16);
		random_items(300);
		// headers two bytes apart share a word
		reconfigure(0, 600, 0, 2);
		random_items(30);
		// regions too small for a heap
		reconfigure(100, 10, 2, 4);
		random_items(8);
		reconfigure(16'hFFFF, 0, 3, 16);
		random_items(5);
		reconfigure(16'h8000, 20000, 2, 4);
		random_items(200);

		drain();
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("[first_fit_coalescing_allocator_core] OK");
		else
			$display("[first_fit_coalescing_allocator_core] ERROR");
		$finish;
	end

endmodule
